// ===== rtl/core/peer_table_with_aging_defines.svh =====
// Assertion macros shared by the peer table RTL.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef PEER_TABLE_WITH_AGING_DEFINES_SVH
`define PEER_TABLE_WITH_AGING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTWA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTWA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ptwa_pkg.sv =====
// Package for the peer table with aging: payload structs, codes and defaults.
// Used by the register, sequencer and top modules; depends on nothing.
package ptwa_pkg;

	localparam int MAX_PEERS_DEF = 8;
	localparam int ID_BYTES_DEF  = 8;

	localparam logic [31:0] BCAST_INTERVAL_RST = 32'd300000;
	localparam logic [31:0] STALE_TIMEOUT_RST  = 32'd900000;

	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [2:0] STAT_UPDATED    = 3'd0;
	localparam logic [2:0] STAT_INSERTED   = 3'd1;
	localparam logic [2:0] STAT_FULL       = 3'd2;
	localparam logic [2:0] STAT_TICK_DONE  = 3'd3;
	localparam logic [2:0] STAT_READ_VALID = 3'd4;
	localparam logic [2:0] STAT_READ_EMPTY = 3'd5;

	localparam logic REG_BCAST_INTERVAL = 1'b0;
	localparam logic REG_STALE_TIMEOUT  = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] now_ms;
		logic [63:0] node_id;
		logic [15:0] bat_mv;
		logic [31:0] uptime;
		logic [31:0] fw_version;
		logic [2:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot;
		logic        broadcast_due;
		logic [3:0]  removed_count;
		logic [3:0]  peer_count;
		logic [63:0] out_node_id;
		logic [15:0] out_bat_mv;
		logic [31:0] out_uptime;
		logic [31:0] out_fw_version;
	} res_t;

	typedef struct packed {
		logic [63:0] node_id;
		logic [15:0] bat_mv;
		logic [31:0] uptime;
		logic [31:0] fw_version;
		logic [31:0] heard_ms;
	} entry_t;

	typedef struct packed {
		logic [31:0] bcast_interval;
		logic [31:0] stale_timeout;
	} cfg_t;

endpackage

// ===== rtl/core/ptwa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the peer table storage.
module ptwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/ptwa_age.sv =====
// Shared age comparator: (now - base) mod 2^32 compared against a limit.
// Used for both the broadcast interval check and the stale entry check.
module ptwa_age (
	input  logic [31:0] now_ms,
	input  logic [31:0] base_ms,
	input  logic [31:0] limit_ms,
	output logic        exceeded
);

	logic [31:0] diff;

	assign diff     = now_ms - base_ms;
	assign exceeded = diff > limit_ms;

endmodule

// ===== rtl/core/ptwa_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on ptwa_pkg for the register layout and reset values.
module ptwa_regs
	import ptwa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bcast_interval <= BCAST_INTERVAL_RST;
			cfg_q.stale_timeout  <= STALE_TIMEOUT_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_STALE_TIMEOUT) begin
				cfg_q.stale_timeout <= pwdata;
			end else begin
				cfg_q.bcast_interval <= pwdata;
			end
		end
	end

	// Only bit 2 selects a register; the low bits are byte offsets.
	assign prdata = (paddr[2] == REG_BCAST_INTERVAL) ? cfg_q.bcast_interval
	                                                 : cfg_q.stale_timeout;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

endmodule

// ===== rtl/core/ptwa_seq.sv =====
// Sequencer for the peer table: walks the entries one per cycle through the
// table RAM and the shared age comparator. Depends on ptwa_pkg and the macros.
`include "peer_table_with_aging_defines.svh"

module ptwa_seq
	import ptwa_pkg::*;
#(
	parameter int MAX_PEERS = MAX_PEERS_DEF,
	parameter int ID_BYTES  = ID_BYTES_DEF,
	localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  req_t          req,
	output logic          done,
	output res_t          res,
	input  cfg_t          cfg,
	output logic [31:0]   age_now,
	output logic [31:0]   age_base,
	output logic [31:0]   age_limit,
	input  logic          age_gt,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output entry_t        mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  entry_t        mem_rdata
);

	localparam int CW = $clog2(MAX_PEERS + 1);
	localparam int KW = (CW > 3) ? CW : 3;
	localparam logic [63:0] ID_MASK =
		(ID_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * ID_BYTES)) - 64'd1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_BCAST = 3'd2;
	localparam logic [2:0] ST_AGE   = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_RDW   = 3'd5;

	logic [2:0]    state_q;
	req_t          req_q;
	logic [CW-1:0] ic_q;
	logic          v_s1;
	logic [AW-1:0] ix_s1;
	logic [CW-1:0] keep_q;
	logic [CW-1:0] removed_q;
	logic [CW-1:0] total_q;
	logic [31:0]   last_bcast_q;
	logic          due_q;
	logic          done_q;
	res_t          res_q;
	res_t          rd_res;

	logic [63:0] id_m;
	logic        id_hit;
	logic        scan_end;
	logic        issue;
	logic        rd_ok;
	logic        has_room;

	function automatic res_t mk_res(logic [2:0] status, logic [2:0] slot, logic due,
	                                logic [3:0] removed, logic [3:0] count);
		res_t r;
		r               = '0;
		r.status        = status;
		r.slot          = slot;
		r.broadcast_due = due;
		r.removed_count = removed;
		r.peer_count    = count;
		return r;
	endfunction

	assign id_m     = req_q.node_id & ID_MASK;
	assign id_hit   = v_s1 && (mem_rdata.node_id == id_m);
	assign scan_end = !v_s1 && (ic_q == total_q);
	assign issue    = ic_q < total_q;
	assign rd_ok    = KW'(req.read_index) < KW'(total_q);
	assign has_room = total_q < CW'(MAX_PEERS);

	// The comparator checks the broadcast interval first, then each entry's age.
	assign age_now   = req_q.now_ms;
	assign age_base  = (state_q == ST_BCAST) ? last_bcast_q : mem_rdata.heard_ms;
	assign age_limit = (state_q == ST_BCAST) ? cfg.bcast_interval : cfg.stale_timeout;

	assign mem_raddr = ic_q[AW-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ix_s1;
		mem_wdata = '{node_id: id_m, bat_mv: req_q.bat_mv,
		              uptime: req_q.uptime, fw_version: req_q.fw_version,
		              heard_ms: req_q.now_ms};
		case (state_q)
			ST_SCAN: begin
				if (id_hit) begin
					mem_we = 1'b1;
				end else if (scan_end && has_room) begin
					mem_we    = 1'b1;
					mem_waddr = total_q[AW-1:0];
				end
			end
			ST_AGE: begin
				// Survivors move down to the next free position, keeping their order.
				if (v_s1 && !age_gt) begin
					mem_we    = 1'b1;
					mem_waddr = keep_q[AW-1:0];
					mem_wdata = mem_rdata;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		rd_res                = mk_res(STAT_READ_VALID, req_q.read_index, 1'b0,
		                               4'd0, 4'(total_q));
		rd_res.out_node_id    = mem_rdata.node_id;
		rd_res.out_bat_mv     = mem_rdata.bat_mv;
		rd_res.out_uptime     = mem_rdata.uptime;
		rd_res.out_fw_version = mem_rdata.fw_version;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ic_q         <= '0;
			v_s1         <= 1'b0;
			ix_s1        <= '0;
			keep_q       <= '0;
			removed_q    <= '0;
			total_q      <= '0;
			last_bcast_q <= '0;
			due_q        <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if ((state_q == ST_SCAN) || (state_q == ST_AGE)) begin
				v_s1  <= issue;
				ix_s1 <= ic_q[AW-1:0];
				if (issue) begin
					ic_q <= ic_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						ic_q      <= '0;
						v_s1      <= 1'b0;
						keep_q    <= '0;
						removed_q <= '0;
						case (req.opcode)
							OP_UPDATE: state_q <= ST_SCAN;
							OP_TICK:   state_q <= ST_BCAST;
							OP_READ: begin
								if (rd_ok) begin
									ic_q    <= CW'(req.read_index);
									state_q <= ST_RD;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (id_hit) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (scan_end) begin
						if (has_room) begin
							total_q <= total_q + 1'b1;
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_BCAST: begin
					due_q <= age_gt;
					if (age_gt) begin
						last_bcast_q <= req_q.now_ms;
					end
					state_q <= ST_AGE;
				end
				ST_AGE: begin
					if (v_s1) begin
						if (age_gt) begin
							removed_q <= removed_q + 1'b1;
						end else begin
							keep_q <= keep_q + 1'b1;
						end
					end else if (scan_end) begin
						total_q <= keep_q;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload; the strobe alone marks it valid.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.opcode == OP_READ) begin
					res_q <= mk_res(STAT_READ_EMPTY, req.read_index, 1'b0, 4'd0, 4'(total_q));
				end else begin
					res_q <= mk_res(STAT_READ_EMPTY, 3'd0, 1'b0, 4'd0, 4'(total_q));
				end
			end
			ST_SCAN: begin
				if (id_hit) begin
					res_q <= mk_res(STAT_UPDATED, 3'(ix_s1), 1'b0, 4'd0, 4'(total_q));
				end else if (has_room) begin
					res_q <= mk_res(STAT_INSERTED, 3'(total_q), 1'b0, 4'd0,
					                4'(total_q + 1'b1));
				end else begin
					res_q <= mk_res(STAT_FULL, 3'd0, 1'b0, 4'd0, 4'(total_q));
				end
			end
			ST_AGE: begin
				res_q <= mk_res(STAT_TICK_DONE, 3'd0, due_q, 4'(removed_q), 4'(keep_q));
			end
			ST_RDW: begin
				res_q <= rd_res;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			req_q <= req;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

	`PTWA_ASSERT_IMP(a_we_in_walk, mem_we, state_q == ST_SCAN || state_q == ST_AGE, "table write outside a walk")
	`PTWA_ASSERT_IMP(a_issue_bound, state_q == ST_SCAN || state_q == ST_AGE, ic_q <= total_q, "issue counter passed the table size")
	`PTWA_ASSERT_IMP(a_compact_count, state_q == ST_AGE && v_s1, CW'(keep_q + removed_q) == CW'(ix_s1), "kept plus removed does not match position")
	`PTWA_ASSERT_IMP(a_insert_grows, done_q && res_q.status == STAT_INSERTED, total_q == CW'($past(total_q) + 1'b1), "insert did not grow the table by one")

endmodule

// ===== rtl/core/peer_table_with_aging.sv =====
// Done strobe: an update walks the stored entries looking for the id; a tick checks the
// broadcast interval, then walks and compacts the entries; a read of a stored entry
// reads the table RAM once; a read past the end or an unused opcode answers from idle.
// Throughput: one transaction at a time; busy stays high until the result is issued,
// set by the walk over the table RAM, one entry per cycle.
// Reset: registers return to their defaults and the table empties at once; no clear pass.
module peer_table_with_aging
	import ptwa_pkg::*;
#(
	parameter int MAX_PEERS = MAX_PEERS_DEF,
	parameter int ID_BYTES  = ID_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

	cfg_t          cfg;
	logic [31:0]   age_now;
	logic [31:0]   age_base;
	logic [31:0]   age_limit;
	logic          age_gt;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	ptwa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ptwa_age u_age (
		.now_ms   (age_now),
		.base_ms  (age_base),
		.limit_ms (age_limit),
		.exceeded (age_gt)
	);

	ptwa_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_PEERS)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ptwa_seq #(
		.MAX_PEERS (MAX_PEERS),
		.ID_BYTES  (ID_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.res       (res),
		.cfg       (cfg),
		.age_now   (age_now),
		.age_base  (age_base),
		.age_limit (age_limit),
		.age_gt    (age_gt),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

// ===== tb/peer_table_with_aging_tb.sv =====
// Self-checking testbench for peer_table_with_aging: directed and random update, tick,
// read and unused-opcode transactions against a shadow copy of the table. Uses ptwa_pkg and the RTL only.
module peer_table_with_aging_tb;
	import ptwa_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [2:0] BCAST_INTERVAL_ADDR = {REG_BCAST_INTERVAL, 2'b00};
	localparam logic [2:0] STALE_TIMEOUT_ADDR  = {REG_STALE_TIMEOUT, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        done;
	res_t        res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	peer_table_with_aging DUT (.*);

	// Shadow copy of the table and its registers.
	entry_t      shadow_table [MAX_PEERS_DEF];
	int unsigned shadow_total = 0;
	logic [31:0] shadow_last_bcast = '0;
	logic [31:0] shadow_interval = BCAST_INTERVAL_RST;
	logic [31:0] shadow_stale = STALE_TIMEOUT_RST;

	req_t        peer_requests [$];
	res_t        replies_due [$];
	res_t        oldest_reply;
	int unsigned items_queued = 0;
	int unsigned items_accepted = 0;
	int unsigned gap_left = 0;
	int unsigned calm_left = 0;
	int unsigned mismatch_total = 0;
	logic [31:0] clock_ms = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic res_t shadow_step(req_t r);
		res_t        o;
		int unsigned i;
		int unsigned pos;
		int unsigned keep;
		int unsigned removed;
		logic        hit;
		logic [31:0] age;
		o = '0;
		case (r.opcode)
			OP_UPDATE: begin
				hit = 1'b0;
				pos = shadow_total;
				for (i = 0; i < shadow_total; i++) begin
					if (!hit && shadow_table[i].node_id == r.node_id) begin
						hit = 1'b1;
						pos = i;
					end
				end
				if (!hit && shadow_total >= MAX_PEERS_DEF) begin
					o.status = STAT_FULL;
				end else begin
					if (hit) begin
						o.status = STAT_UPDATED;
					end else begin
						shadow_table[pos].node_id = r.node_id;
						shadow_total++;
						o.status = STAT_INSERTED;
					end
					shadow_table[pos].bat_mv = r.bat_mv;
					shadow_table[pos].uptime = r.uptime;
					shadow_table[pos].fw_version = r.fw_version;
					shadow_table[pos].heard_ms = r.now_ms;
					o.slot = 3'(pos);
				end
			end
			OP_TICK: begin
				age = r.now_ms - shadow_last_bcast;
				if (age > shadow_interval) begin
					o.broadcast_due = 1'b1;
					shadow_last_bcast = r.now_ms;
				end
				keep = 0;
				removed = 0;
				// Survivors slide down so the table keeps its arrival order.
				for (i = 0; i < shadow_total; i++) begin
					age = r.now_ms - shadow_table[i].heard_ms;
					if (age > shadow_stale) begin
						removed++;
					end else begin
						shadow_table[keep] = shadow_table[i];
						keep++;
					end
				end
				shadow_total = keep;
				o.status = STAT_TICK_DONE;
				o.removed_count = 4'(removed);
			end
			OP_READ: begin
				o.slot = r.read_index;
				if (r.read_index < shadow_total) begin
					o.status = STAT_READ_VALID;
					o.out_node_id = shadow_table[r.read_index].node_id;
					o.out_bat_mv = shadow_table[r.read_index].bat_mv;
					o.out_uptime = shadow_table[r.read_index].uptime;
					o.out_fw_version = shadow_table[r.read_index].fw_version;
				end else begin
					o.status = STAT_READ_EMPTY;
				end
			end
			default: begin
				o.status = STAT_READ_EMPTY;
			end
		endcase
		o.peer_count = 4'(shadow_total);
		return o;
	endfunction

	function automatic int unsigned draw_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 0;
		else if (roll < 80)
			return $urandom_range(1, 4);
		else if (roll < 95)
			return $urandom_range(5, 15);
		else
			return $urandom_range(30, 80);
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_total++;
		end
	endfunction

	task automatic queue_request(logic [1:0] op, logic [31:0] now, logic [63:0] id,
		logic [15:0] bat, logic [31:0] up, logic [31:0] fw, logic [2:0] idx);
		req_t r;
		r.opcode = op;
		r.now_ms = now;
		r.node_id = id;
		r.bat_mv = bat;
		r.uptime = up;
		r.fw_version = fw;
		r.read_index = idx;
		peer_requests = {peer_requests, r};
		items_queued++;
	endtask

	// Updates mostly reuse a small pool of ids so that hits, full drops and aging all occur.
	task automatic queue_random_phase(int unsigned count, int unsigned step_max);
		logic [63:0] ids [12];
		int unsigned n;
		int unsigned roll;
		logic [1:0]  op;
		logic [63:0] id;
		for (n = 0; n < 12; n++)
			ids[n] = {$urandom, $urandom};
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 50)
				op = OP_UPDATE;
			else if (roll < 75)
				op = OP_TICK;
			else if (roll < 95)
				op = OP_READ;
			else
				op = OP_UNUSED;
			if ($urandom_range(0, 19) == 0)
				clock_ms = $urandom;
			else
				clock_ms += $urandom_range(0, step_max);
			if ($urandom_range(0, 6) == 0)
				id = {$urandom, $urandom};
			else
				id = ids[$urandom_range(0, 11)];
			queue_request(op, clock_ms, id, 16'($urandom), $urandom, $urandom,
				3'($urandom_range(0, 7)));
		end
	endtask

	task automatic write_reg(logic reg_index, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= (reg_index == REG_BCAST_INTERVAL) ? BCAST_INTERVAL_ADDR : STALE_TIMEOUT_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_index == REG_BCAST_INTERVAL)
			shadow_interval = value;
		else
			shadow_stale = value;
	endtask

	task automatic wait_idle();
		int unsigned waited;
		waited = 0;
		while ((items_accepted != items_queued || replies_due.size() != 0 || busy)
			&& waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (replies_due.size() != 0) begin
			$error("%0d transactions never produced a result", replies_due.size());
			mismatch_total++;
		end
	endtask

	// Driver: holds a request until the block takes it, then idles for a random gap.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				replies_due = {replies_due, shadow_step(req)};
				items_accepted++;
				if (calm_left > 0) begin
					calm_left--;
					gap_left = 0;
				end else begin
					gap_left = draw_gap();
					if ($urandom_range(0, 15) == 0)
						calm_left = $urandom_range(10, 40);
				end
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (peer_requests.size() > 0) begin
					req <= peer_requests.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("result with no transaction waiting for it, status %0d", res.status);
				mismatch_total++;
			end else begin
				oldest_reply = replies_due.pop_front();
				check_field("status", oldest_reply.status, res.status);
				check_field("slot", oldest_reply.slot, res.slot);
				check_field("broadcast_due", oldest_reply.broadcast_due, res.broadcast_due);
				check_field("removed_count", oldest_reply.removed_count, res.removed_count);
				check_field("peer_count", oldest_reply.peer_count, res.peer_count);
				check_field("out_node_id", oldest_reply.out_node_id, res.out_node_id);
				check_field("out_bat_mv", oldest_reply.out_bat_mv, res.out_bat_mv);
				check_field("out_uptime", oldest_reply.out_uptime, res.out_uptime);
				check_field("out_fw_version", oldest_reply.out_fw_version, res.out_fw_version);
			end
		end
	end

	initial begin
		int unsigned k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset register values.
		queue_request(OP_READ, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 3'd0);
		queue_request(OP_UNUSED, '1, '1, '1, '1, '1, 3'd7);
		queue_request(OP_UPDATE, 32'hFFFF_FFF0, '1, '1, '1, '1, 3'd7);
		queue_request(OP_UPDATE, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 3'd0);
		queue_request(OP_UPDATE, 32'h10, '1, 16'h1234, 32'h5678, 32'h9ABC, 3'd0);
		for (k = 2; k < 8; k++)
			queue_request(OP_UPDATE, k * 100000, 64'h0100 + k, 16'(k), k, ~k, 3'd0);
		// The table is full now, so a new id must be dropped.
		queue_request(OP_UPDATE, 32'd750000, 64'h8000_0000_0000_0001, 16'd9, 32'd9, 32'd9, 3'd0);
		queue_request(OP_READ, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 3'd7);
		// Removes the two entries at the front and compacts the rest.
		queue_request(OP_TICK, 32'd1000000, 64'd0, 16'd0, 32'd0, 32'd0, 3'd0);
		queue_request(OP_READ, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 3'd0);
		queue_request(OP_READ, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 3'd5);
		queue_request(OP_READ, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 3'd6);
		// Both limits are hit exactly, then exceeded by one millisecond.
		queue_request(OP_TICK, 32'd1300000, 64'd0, 16'd0, 32'd0, 32'd0, 3'd0);
		queue_request(OP_TICK, 32'd1300001, 64'd0, 16'd0, 32'd0, 32'd0, 3'd0);
		queue_request(OP_READ, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 3'd7);
		clock_ms = 32'd1300001;
		queue_random_phase(120, 150000);

		wait_idle();
		write_reg(REG_BCAST_INTERVAL, 32'd0);
		write_reg(REG_STALE_TIMEOUT, 32'd0);
		queue_random_phase(130, 3);

		wait_idle();
		write_reg(REG_BCAST_INTERVAL, '1);
		write_reg(REG_STALE_TIMEOUT, '1);
		queue_random_phase(130, 32'h0100_0000);

		wait_idle();
		write_reg(REG_BCAST_INTERVAL, $urandom_range(1000, 50000));
		write_reg(REG_STALE_TIMEOUT, $urandom_range(5000, 120000));
		queue_random_phase(150, 20000);

		wait_idle();
		write_reg(REG_BCAST_INTERVAL, $urandom);
		write_reg(REG_STALE_TIMEOUT, $urandom);
		queue_random_phase(150, 32'h4000_0000);

		wait_idle();
		repeat (16) @(posedge clk);
		if (mismatch_total == 0)
			$display("peer_table_with_aging_tb passed");
		else
			$display("peer_table_with_aging_tb failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("peer_table_with_aging_tb failed");
		$finish;
	end

endmodule
